// ===== rtl/rttu_pkg.sv =====
// shared types and constants of the retransmit tracking table unit
// no dependencies; every other file uses this package
package rttu_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam int CMD_W    = 16;
    localparam int STAMP_W  = 32;
    localparam int PACKET_W = 32;
    localparam int WAIT_W   = 16;
    localparam int SEND_W   = 8;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TICKS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SENDS  = CFG_IDX_W'(1);

    localparam logic [WAIT_W-1:0] WAIT_TICKS_RST = WAIT_W'(10);
    localparam logic [SEND_W-1:0] MAX_SENDS_RST  = SEND_W'(3);

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_QUERY  = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_TICK   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_DONE   = 2'd0,
        KIND_RESEND = 2'd1,
        KIND_FAIL   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                valid;
        logic [CMD_W-1:0]    cmd;
        logic [STAMP_W-1:0]  stamp;
        logic [PACKET_W-1:0] packet;
        logic [WAIT_W-1:0]   wait_cnt;
        logic [SEND_W-1:0]   send_cnt;
    } entry_t;

    // ring control from the head logic to the cells
    typedef struct packed {
        logic   shift;
        entry_t feed;
    } ring_ctl_t;

endpackage

// ===== rtl/rttu_if.sv =====
// handshake channels of the retransmit tracking table unit
// depends on rttu_pkg
interface rttu_in_if;
    logic                          valid;
    logic                          ready;
    rttu_pkg::func_t               func;
    logic [rttu_pkg::CMD_W-1:0]    cmd_code;
    logic [rttu_pkg::STAMP_W-1:0]  server_stamp;
    logic [rttu_pkg::PACKET_W-1:0] packet_number;

    modport source (output valid, func, cmd_code, server_stamp, packet_number, input ready);
    modport sink   (input valid, func, cmd_code, server_stamp, packet_number, output ready);
endinterface

interface rttu_out_if;
    logic                          valid;
    logic                          ready;
    rttu_pkg::kind_t               kind;
    logic                          found;
    logic                          table_full;
    logic [rttu_pkg::CMD_W-1:0]    out_cmd;
    logic [rttu_pkg::STAMP_W-1:0]  out_stamp;
    logic [rttu_pkg::PACKET_W-1:0] out_packet;
    logic                          last;

    modport source (output valid, kind, found, table_full, out_cmd, out_stamp, out_packet,
                    last, input ready);
    modport sink   (input valid, kind, found, table_full, out_cmd, out_stamp, out_packet,
                    last, output ready);
endinterface

interface rttu_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rttu_pkg::CFG_IDX_W-1:0]  index;
    logic [rttu_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/retransmit_tracking_table_unit.sv =====
// top level of the retransmit tracking table: ring of slot cells plus sequencer
// depends on rttu_pkg, rttu_if, rttu_cell and rttu_ctrl
//
// usage
// - request channel: one item per operation (add, query, delete, tick) with its key
// - result channel: one or more items per request; the final one carries last
// - cfg channel: register writes (wait_ticks, max_sends), always ready; write only
//   while no request is in progress
// - the table is a ring of TABLE_DEPTH cells that turns one slot per unstalled cycle
//   in a walk; the sequencer takes the head entry, so slots are seen in slot order
// - query, delete, a tick with no failure and an add that does not insert load their
//   final result after one lap of the ring; an add that inserts takes a search lap,
//   then a write lap; one request at a time
// - the next request can be taken in the cycle after a done result is loaded; a tick
//   that fails the link ends on its fail result and frees the sequencer at the end
//   of its lap
// - the rotation sets the rate: one slot per unstalled cycle through one head unit
// - a stalled result holds the ring in place at the next slot that has a result;
//   the result register lets a new request enter while the final result waits
// - after a link failure the ring keeps turning without changes so it ends in order
// - reset clears all valid bits at once and loads the register defaults; no sweep
module retransmit_tracking_table_unit (
    input logic        clk,
    input logic        rst_n,
    rttu_in_if.sink    request,
    rttu_out_if.source result,
    rttu_cfg_if.sink   cfg
);
    import rttu_pkg::*;

    logic [WAIT_W-1:0] wait_ticks_reg;
    logic [SEND_W-1:0] max_sends_reg;
    ring_ctl_t         ring_ctl;
    entry_t            cell_q [TABLE_DEPTH];

    // config registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_ticks_reg <= WAIT_TICKS_RST;
            max_sends_reg  <= MAX_SENDS_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_WAIT_TICKS: wait_ticks_reg <= cfg.data[WAIT_W-1:0];
                CFG_MAX_SENDS:  max_sends_reg  <= cfg.data[SEND_W-1:0];
                default:        ;
            endcase
        end
    end

    // ring: each cell loads from its upper neighbor, the top cell from the head logic
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        entry_t cell_d;
        if (i == TABLE_DEPTH - 1)
        begin : g_top
            assign cell_d = ring_ctl.feed;
        end
        else
        begin : g_mid
            assign cell_d = cell_q[i+1];
        end
        rttu_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (ring_ctl.shift),
            .d     (cell_d),
            .q     (cell_q[i])
        );
    end

    rttu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .result     (result),
        .wait_ticks (wait_ticks_reg),
        .max_sends  (max_sends_reg),
        .head       (cell_q[0]),
        .ring_ctl   (ring_ctl)
    );

endmodule

// ===== rtl/rttu_cell.sv =====
// one table slot of the rotating ring
// depends on rttu_pkg
module rttu_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  rttu_pkg::entry_t d,
    output rttu_pkg::entry_t q
);
    import rttu_pkg::*;

    logic   valid_reg;
    entry_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (shift)
            valid_reg <= d.valid;
    end

    always_ff @(posedge clk)
    begin
        if (shift)
            entry_reg <= d;
    end

    always_comb
    begin
        q       = entry_reg;
        q.valid = valid_reg;
    end

endmodule

// ===== rtl/rttu_ctrl.sv =====
// head-of-ring sequencer: walks the slots, updates the head entry, emits results
// depends on rttu_pkg and rttu_if
module rttu_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    rttu_in_if.sink                     request,
    rttu_out_if.source                  result,
    input  logic [rttu_pkg::WAIT_W-1:0] wait_ticks,
    input  logic [rttu_pkg::SEND_W-1:0] max_sends,
    input  rttu_pkg::entry_t            head,
    output rttu_pkg::ring_ctl_t         ring_ctl
);
    import rttu_pkg::*;

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_DEPTH - 1);

    state_t              state_reg, state_next;
    func_t               func_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [STAMP_W-1:0]  stamp_reg;
    logic [PACKET_W-1:0] packet_reg;
    logic [IDX_W-1:0]    step_reg;
    logic                hit_reg, hit_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic                failed_reg, failed_next;
    logic                pass2_reg;

    logic                out_valid_reg;
    kind_t               out_kind_reg;
    logic                out_found_reg, out_full_reg, out_last_reg;
    logic [CMD_W-1:0]    out_cmd_reg;
    logic [STAMP_W-1:0]  out_stamp_reg;
    logic [PACKET_W-1:0] out_packet_reg;

    entry_t feed;
    logic   match, emit, r_last;
    kind_t  r_kind;
    logic   accept, can_emit, step_go, last_step, finish_go, emit_now;

    assign accept    = request.valid && request.ready;
    assign can_emit  = !out_valid_reg || result.ready;
    assign last_step = (step_reg == LAST_STEP);
    assign step_go   = (state_reg == ST_WALK) && (!emit || can_emit);
    assign finish_go = (state_reg == ST_FINISH) && can_emit;
    assign emit_now  = (step_go && emit) || finish_go;

    // head entry processing for the current step
    always_comb
    begin
        feed            = head;
        emit            = 1'b0;
        r_kind          = KIND_DONE;
        r_last          = 1'b0;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        failed_next     = failed_reg;
        match = head.valid && (head.cmd == cmd_reg) && (head.stamp == stamp_reg)
                && (head.packet == packet_reg);
        case (func_reg)
            FUNC_TICK:
            begin
                if (!failed_reg && head.valid)
                begin
                    if (head.send_cnt > max_sends)
                    begin
                        emit        = 1'b1;
                        r_kind      = KIND_FAIL;
                        r_last      = 1'b1;
                        failed_next = 1'b1;
                    end
                    else if (head.wait_cnt > wait_ticks)
                    begin
                        feed.wait_cnt = '0;
                        if (head.send_cnt != '1)
                            feed.send_cnt = head.send_cnt + SEND_W'(1);
                        emit   = 1'b1;
                        r_kind = KIND_RESEND;
                    end
                    else if (head.wait_cnt != '1)
                    begin
                        feed.wait_cnt = head.wait_cnt + WAIT_W'(1);
                    end
                end
            end
            FUNC_QUERY:
                hit_next = hit_reg || match;
            FUNC_DELETE:
            begin
                if (match && !hit_reg)
                    feed.valid = 1'b0;
                hit_next = hit_reg || match;
            end
            default:
            begin
                // add: first pass searches, second pass writes the free slot
                if (!pass2_reg)
                begin
                    hit_next = hit_reg || match;
                    if (!head.valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = step_reg;
                    end
                end
                else if (step_reg == free_idx_reg)
                begin
                    feed.valid    = 1'b1;
                    feed.cmd      = cmd_reg;
                    feed.stamp    = stamp_reg;
                    feed.packet   = packet_reg;
                    feed.wait_cnt = '0;
                    feed.send_cnt = '0;
                end
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_WALK;
            ST_WALK:
                if (step_go && last_step)
                begin
                    if (func_reg == FUNC_ADD && !pass2_reg && !hit_next && free_found_next)
                        state_next = ST_WALK;
                    else if (failed_next)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_FINISH;
                end
            ST_FINISH:
                if (finish_go)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        request.ready  = 1'b0;
        ring_ctl.shift = 1'b0;
        ring_ctl.feed  = feed;
        unique case (state_reg)
            ST_IDLE:   request.ready  = 1'b1;
            ST_WALK:   ring_ctl.shift = step_go;
            ST_FINISH: ;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            failed_reg     <= 1'b0;
            pass2_reg      <= 1'b0;
            func_reg       <= FUNC_ADD;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                func_reg       <= request.func;
                step_reg       <= '0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                free_idx_reg   <= '0;
                failed_reg     <= 1'b0;
                pass2_reg      <= 1'b0;
            end
            else if (step_go)
            begin
                step_reg       <= last_step ? '0 : step_reg + IDX_W'(1);
                hit_reg        <= hit_next;
                free_found_reg <= free_found_next;
                free_idx_reg   <= free_idx_next;
                failed_reg     <= failed_next;
                if (last_step)
                    pass2_reg <= 1'b1;
            end
            if (emit_now)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // key and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= request.cmd_code;
            stamp_reg  <= request.server_stamp;
            packet_reg <= request.packet_number;
        end
        if (step_go && emit)
        begin
            out_kind_reg   <= r_kind;
            out_found_reg  <= 1'b0;
            out_full_reg   <= 1'b0;
            out_cmd_reg    <= head.cmd;
            out_stamp_reg  <= head.stamp;
            out_packet_reg <= head.packet;
            out_last_reg   <= r_last;
        end
        else if (finish_go)
        begin
            out_kind_reg   <= KIND_DONE;
            out_found_reg  <= (func_reg != FUNC_TICK) && hit_reg;
            out_full_reg   <= (func_reg == FUNC_ADD) && !hit_reg && !free_found_reg;
            out_cmd_reg    <= '0;
            out_stamp_reg  <= '0;
            out_packet_reg <= '0;
            out_last_reg   <= 1'b1;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.kind       = out_kind_reg;
    assign result.found      = out_found_reg;
    assign result.table_full = out_full_reg;
    assign result.out_cmd    = out_cmd_reg;
    assign result.out_stamp  = out_stamp_reg;
    assign result.out_packet = out_packet_reg;
    assign result.last       = out_last_reg;

endmodule

// ===== rtl/rttu_checker.sv =====
// port-level checks of the retransmit tracking table unit, bound to the top level
// depends on rttu_pkg and retransmit_tracking_table_unit
module rttu_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input rttu_pkg::kind_t               kind,
    input logic                          found,
    input logic                          table_full,
    input logic [rttu_pkg::CMD_W-1:0]    out_cmd,
    input logic                          last
);
    import rttu_pkg::*;

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while previous one in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(out_cmd)
                                       && $stable(last)))
        else $error("stalled result changed");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_DONE) |-> last)
        else $error("done result without last");

    a_tick_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_DONE) |-> (!found && !table_full))
        else $error("tick result with lookup flags");

    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && table_full) |-> (!found && last))
        else $error("table full together with found");

endmodule

bind retransmit_tracking_table_unit rttu_checker u_rttu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (request.valid),
    .in_ready   (request.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .kind       (result.kind),
    .found      (result.found),
    .table_full (result.table_full),
    .out_cmd    (result.out_cmd),
    .last       (result.last)
);
